// File: hdl/led_pattern_pulse_pwm_driver_assert.svh
// assertion macros for the led pattern pulse pwm driver
`ifndef LED_PATTERN_PULSE_PWM_DRIVER_ASSERT_SVH
`define LED_PATTERN_PULSE_PWM_DRIVER_ASSERT_SVH
// implication checked on every clock edge outside reset
`define LPPD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define LPPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: hdl/lppd_pkg.sv
// shared types, constants and helpers for the led driver
package lppd_pkg;
  localparam int PATTERN_MAX = 32;
  localparam int BRIGHT_MAX = 100;
  localparam int PWM_TOP = 1023;
  localparam int STEP_PERIOD_MS = 250;
  // 2^24 / BRIGHT_MAX rounded up, exact for every level times PWM_TOP
  localparam int PWM_RECIP_SHIFT = 24;
  localparam int PWM_RECIP = ((1 << PWM_RECIP_SHIFT) + BRIGHT_MAX - 1) / BRIGHT_MAX;

  localparam logic [1:0] MODE_STEADY = 2'd0;
  localparam logic [1:0] MODE_PATTERN = 2'd1;
  localparam logic [1:0] MODE_PULSE = 2'd2;

  localparam logic [1:0] SYM_OFF = 2'd0;
  localparam logic [1:0] SYM_ON = 2'd1;
  localparam logic [1:0] SYM_UP = 2'd2;
  localparam logic [1:0] SYM_DOWN = 2'd3;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_STEADY = 3'd1;
  localparam logic [2:0] REG_PERIOD = 3'd2;
  localparam logic [2:0] REG_SYMBOLS = 3'd3;
  localparam logic [2:0] REG_LENGTH = 3'd4;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture input time, decide action
    logic div_start;  // start divider
    logic div_step;   // one divider iteration
    logic scan_step;  // one ramp scan step
    logic finish;     // compute final level
  } lppd_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_done;
    logic scan_done;
  } lppd_sts_t;

  function automatic logic [9:0] pwm_of(input logic [6:0] lvl);
    logic [16:0] prod;
    logic [34:0] scaled;
    begin
      prod = 17'(lvl) * 17'(PWM_TOP);
      scaled = 35'(prod) * 35'(PWM_RECIP);
      return scaled[PWM_RECIP_SHIFT +: 10];
    end
  endfunction
endpackage

// File: hdl/led_pattern_pulse_pwm_driver.sv
// top level of the led pattern pulse pwm driver
// One loop-call item in, one result out. Steady mode, mode three, an item with no update
// due and a pattern step on an on or off symbol go from the decision state straight to
// the final level. A pattern ramp scans its run one position each way per cycle and then
// runs the restoring divider. Pulse mode runs two passes of the divider, time modulo
// period, then the level scaling. The result waits while the result side stalls; the
// next input transfer can happen in the same cycle as the result transfer.
// Only one item is in work at a time; the result register holds until it is taken.
`include "led_pattern_pulse_pwm_driver_assert.svh"
module led_pattern_pulse_pwm_driver import lppd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] time_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  level,
  output logic [9:0]  pwm_value,
  output logic        updated
);
  lppd_cmd_t cmd;
  lppd_sts_t sts;
  logic need_div, need_scan;

  lppd_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .need_div, .need_scan, .sts, .cmd
  );

  lppd_dp u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .time_ms, .cmd, .sts,
    .need_div, .need_scan, .level, .pwm_value, .updated
  );

  `LPPD_ASSERT_IMP(a_level_max, out_valid, level <= 7'(BRIGHT_MAX))
  `LPPD_ASSERT_IMP(a_no_accept_busy, in_ready && !out_valid, !cmd.div_step)
  `LPPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(level))
endmodule

// File: hdl/lppd_ctrl.sv
// controller state machine for the led driver
module lppd_ctrl import lppd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  logic      need_div,
  input  logic      need_scan,
  input  lppd_sts_t sts,
  output lppd_cmd_t cmd
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MOD = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_DIV = 3'd3;
  localparam logic [2:0] ST_FIN = 3'd4;
  localparam logic [2:0] ST_OUT = 3'd5;

  logic [2:0] state, state_next;
  logic phase, phase_next;  // 0: modulo divide, 1: level divide

  assign in_ready = (state == ST_IDLE) || (state == ST_OUT && out_ready);
  assign out_valid = (state == ST_OUT);

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        // datapath decided after load
        if (need_div) begin
          cmd.div_start = 1'b1;
          phase_next = 1'b0;
          state_next = ST_DIV;
        end else if (need_scan) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          cmd.div_start = 1'b1;
          phase_next = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          if (!phase) begin
            cmd.div_start = 1'b1;
            phase_next = 1'b1;
          end else begin
            state_next = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          if (in_valid) begin
            cmd.load = 1'b1;
            state_next = ST_MOD;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end
endmodule

// File: hdl/lppd_dp.sv
// datapath: config registers, timing state, divider and ramp scan
module lppd_dp import lppd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic [31:0] time_ms,
  input  lppd_cmd_t   cmd,
  output lppd_sts_t   sts,
  output logic        need_div,
  output logic        need_scan,
  output logic [6:0]  level,
  output logic [9:0]  pwm_value,
  output logic        updated
);
  logic [1:0]  mode;
  logic [7:0]  steady_level;
  logic [15:0] pulse_period_ms;
  logic [63:0] pattern_symbols;
  logic [5:0]  pattern_length;
  logic [31:0] next_step_time;
  logic [4:0]  pattern_position;
  logic [6:0]  current_level;
  logic        steady_pending;

  logic [31:0] t;
  logic        upd;
  logic [1:0]  sym;
  logic [1:0]  sym_new;
  logic [5:0]  len;
  logic [4:0]  pos_new;

  // scan state
  logic [4:0]  scan_lo, scan_hi;
  logic        lo_run, hi_run;

  // divider: restoring, 32-bit dividend
  logic [31:0] dq;
  logic [15:0] dr;
  logic [15:0] dd;
  logic [5:0]  dcnt;
  logic [16:0] shl;
  logic [17:0] trial;
  logic [15:0] rem_next;
  logic        half_side;
  logic [15:0] half;

  function automatic logic [1:0] sym_at(input logic [63:0] s, input logic [4:0] p);
    return s[{p, 1'b0} +: 2];
  endfunction

  assign len = (pattern_length > 6'(PATTERN_MAX)) ? 6'(PATTERN_MAX) : pattern_length;
  assign pos_new = (6'(pattern_position) + 6'd1 >= len) ? 5'd0 : pattern_position + 5'd1;
  assign sym_new = sym_at(pattern_symbols, pos_new);
  assign half = pulse_period_ms >> 1;
  assign shl = {dr, dq[31]};
  assign trial = {1'b0, shl} - {2'b00, dd};
  assign rem_next = trial[17] ? shl[15:0] : trial[15:0];
  assign sts.div_done = (dcnt == 6'd1);
  assign sts.scan_done = !lo_run && !hi_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_STEADY;
      steady_level <= '0;
      pulse_period_ms <= '0;
      pattern_symbols <= '0;
      pattern_length <= '0;
      next_step_time <= '0;
      pattern_position <= '0;
      current_level <= '0;
      steady_pending <= 1'b1;
      upd <= 1'b0;
      need_div <= 1'b0;
      need_scan <= 1'b0;
      dcnt <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE: begin
            mode <= cfg_data[1:0];
            next_step_time <= '0;
            if (cfg_data[1:0] == MODE_STEADY) steady_pending <= 1'b1;
          end
          REG_STEADY: begin
            steady_level <= cfg_data[7:0];
            steady_pending <= 1'b1;
          end
          REG_PERIOD: pulse_period_ms <= cfg_data[15:0];
          REG_SYMBOLS: begin
            pattern_symbols <= cfg_data;
            next_step_time <= '0;
          end
          REG_LENGTH: begin
            pattern_length <= cfg_data[5:0];
            next_step_time <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.load) begin
        t <= time_ms;
        upd <= 1'b0;
        need_div <= 1'b0;
        need_scan <= 1'b0;
        case (mode)
          MODE_STEADY: begin
            if (steady_pending) begin
              upd <= 1'b1;
              steady_pending <= 1'b0;
            end
          end
          MODE_PATTERN: begin
            if (len != 6'd0 && time_ms >= next_step_time) begin
              upd <= 1'b1;
              pattern_position <= pos_new;
              next_step_time <= time_ms + 32'(STEP_PERIOD_MS);
              sym <= sym_new;
              scan_lo <= pos_new;
              scan_hi <= pos_new;
              lo_run <= 1'b1;
              hi_run <= 1'b1;
              need_scan <= sym_new[1];
            end
          end
          MODE_PULSE: begin
            if (pulse_period_ms != 16'd0) begin
              upd <= 1'b1;
              need_div <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (cmd.scan_step) begin
        // grow the run one position each way per cycle
        if (lo_run) begin
          if (scan_lo != 5'd0 && sym_at(pattern_symbols, scan_lo - 5'd1) == sym)
            scan_lo <= scan_lo - 5'd1;
          else
            lo_run <= 1'b0;
        end
        if (hi_run) begin
          if (6'(scan_hi) + 6'd1 < len && sym_at(pattern_symbols, scan_hi + 5'd1) == sym)
            scan_hi <= scan_hi + 5'd1;
          else
            hi_run <= 1'b0;
        end
      end
      if (cmd.div_start) begin
        dr <= '0;
        if (cmd.scan_step) begin
          // ramp: BRIGHT_MAX / (n + 1)
          dq <= 32'(BRIGHT_MAX);
          dd <= 16'(scan_hi - scan_lo) + 16'd2;
          dcnt <= 6'd32;
        end else if (cmd.load == 1'b0 && dcnt == 6'd1) begin
          // second pass: pulse level, last modulo step folded in
          if (rem_next < half) begin
            half_side <= 1'b0;
            dq <= 32'(rem_next) * 32'(BRIGHT_MAX);
            dd <= half;
          end else begin
            half_side <= 1'b1;
            dq <= 32'(rem_next - half) * 32'(BRIGHT_MAX);
            dd <= pulse_period_ms - half;
          end
          dcnt <= 6'd32;
        end else begin
          dq <= t;
          dd <= pulse_period_ms;
          dcnt <= 6'd32;
        end
      end else if (cmd.div_step) begin
        if (trial[17]) begin
          dr <= shl[15:0];
          dq <= {dq[30:0], 1'b0};
        end else begin
          dr <= trial[15:0];
          dq <= {dq[30:0], 1'b1};
        end
        dcnt <= dcnt - 6'd1;
      end
      if (cmd.finish && upd) begin
        case (mode)
          MODE_STEADY:
            current_level <= (steady_level > 8'(BRIGHT_MAX)) ? 7'(BRIGHT_MAX)
                             : steady_level[6:0];
          MODE_PATTERN: begin
            case (sym)
              SYM_OFF: current_level <= '0;
              SYM_ON:  current_level <= 7'(BRIGHT_MAX);
              SYM_UP:  current_level <= 7'(dq[6:0]
                                        * (7'(pattern_position - scan_lo) + 7'd1));
              default: current_level <= 7'(BRIGHT_MAX)
                                        - 7'(dq[6:0]
                                        * (7'(pattern_position - scan_lo) + 7'd1));
            endcase
          end
          default: begin
            if (!half_side)
              current_level <= (dq > 32'(BRIGHT_MAX)) ? 7'(BRIGHT_MAX) : dq[6:0];
            else
              current_level <= 7'(BRIGHT_MAX) - dq[6:0];
          end
        endcase
      end
    end
  end

  assign pwm_value = pwm_of(current_level);
  assign level = current_level;
  assign updated = upd;
endmodule
